// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands on clk; arst_n masks BAGC_ASSERT only
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BAGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BAGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bagc_pkg.sv =====
// ----------------------------------------------------------------------------
// bagc_pkg
// types, constants and helpers of the bagging cycle sequencer
// ----------------------------------------------------------------------------
package bagc_pkg;

	localparam int DELAY_BITS = 16;
	localparam int COUNT_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE_DELAY = 3'd0,
		REG_FILL_TIME    = 3'd1,
		REG_BLADE_TIME   = 3'd2,
		REG_RELEASE_TIME = 3'd3,
		REG_JAW_OPEN     = 3'd4,
		REG_PHOTO_MODE   = 3'd5,
		REG_DRY_RUN      = 3'd6,
		REG_BATCH_SIZE   = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] SETTLE_DELAY_RST = 16'd100;
	localparam logic [CFG_W-1:0] FILL_TIME_RST    = 16'd300;
	localparam logic [CFG_W-1:0] BLADE_TIME_RST   = 16'd100;
	localparam logic [CFG_W-1:0] RELEASE_TIME_RST = 16'd150;
	localparam logic [CFG_W-1:0] JAW_OPEN_RST     = 16'd50;
	localparam logic [CFG_W-1:0] BATCH_SIZE_RST   = 16'd100;

	typedef enum logic [13:0] {
		PH_HOMING   = 14'b00000000000001,
		PH_IDLE     = 14'b00000000000010,
		PH_CHECK    = 14'b00000000000100,
		PH_SETTLE   = 14'b00000000001000,
		PH_FILL1    = 14'b00000000010000,
		PH_FILL2    = 14'b00000000100000,
		PH_JAWOPEN  = 14'b00000001000000,
		PH_BLADE    = 14'b00000010000000,
		PH_RELEASE  = 14'b00000100000000,
		PH_WAITUP   = 14'b00001000000000,
		PH_DFILL1   = 14'b00010000000000,
		PH_DFILL2   = 14'b00100000000000,
		PH_DBLADE   = 14'b01000000000000,
		PH_DRELEASE = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic med;
		logic slow;
		logic doser;
		logic blade;
		logic vjaw;
		logic hjaw;
		logic down;
	} act_t;

	localparam act_t ACT_RST = '{med: 1'b1, default: 1'b0};

	typedef struct packed {
		logic ms_tick;
		logic start_button_n;
		logic stop_button_n;
		logic photocell_level;
		logic upper_limit;
		logic lower_limit;
	} sample_t;

	typedef struct packed {
		logic        carriage_down;
		logic        horizontal_jaw_closed;
		logic        vertical_jaw_closed;
		logic        blade_on;
		logic        doser_open;
		logic        slow_speed_select;
		logic        medium_speed_select;
		logic [15:0] bags_remaining;
		logic        running;
		logic        homing;
		logic        bottom_fault;
	} result_t;

	// clamp a register value to the delay timer range
	function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [CFG_W-1:0] v);
		logic [DELAY_BITS-1:0] r;
		if (DELAY_BITS >= CFG_W) r = DELAY_BITS'(v);
		else if ((v >> DELAY_BITS) != '0) r = '1;
		else r = DELAY_BITS'(v);
		return r;
	endfunction

	// clamp a register value to the bag counter range
	function automatic logic [COUNT_BITS-1:0] sat_count(input logic [CFG_W-1:0] v);
		logic [COUNT_BITS-1:0] r;
		if (COUNT_BITS >= CFG_W) r = COUNT_BITS'(v);
		else if ((v >> COUNT_BITS) != '0) r = '1;
		else r = COUNT_BITS'(v);
		return r;
	endfunction

endpackage

// ===== design/bagc_if.sv =====
// ----------------------------------------------------------------------------
// bagc_if
// valid/ready channels for pin samples and actuator results
// ----------------------------------------------------------------------------
interface bagc_sample_if import bagc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bagc_result_if import bagc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bagging_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// bagging_cycle_sequencer
// actuator sequencer for a bag-forming machine, one pin sample per request
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+-------------
//  sample   | in  | tick, buttons, photocell, limit pins  | valid/ready
//  result   | out | actuators, bags left, status, fault   | valid/ready
//  cfg      | in  | register index and data               | write enable
//
//  one request per cycle unless stalled: the phase update and its single
//  timer compare sit between the state registers and the result register
//  each accepted request yields exactly one registered result
//  a two-entry output buffer (result register plus skid) keeps ready high
//  while one result waits; ready drops only when both entries are full
//  arst_n clears phase to homing, timers, counter, flags, edge history and
//  the config registers to their defaults
//
`include "assert_macros.svh"

module bagging_cycle_sequencer import bagc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bagc_sample_if.sink          sample,
	bagc_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// configuration registers
	logic [CFG_W-1:0] settle_delay_q, fill_time_q, blade_time_q;
	logic [CFG_W-1:0] release_time_q, jaw_open_q, batch_size_q;
	logic             photo_mode_q, dry_run_q;

	// sequencer state
	phase_t                phase_q, phase_n;
	logic [DELAY_BITS-1:0] timer_q, timer_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic                  arrived_q, arrived_n;
	logic                  paused_q, paused_n;
	logic [2:0]            prev_q;
	act_t                  act_q, act_n;

	// output buffer
	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;

	// per-request decode
	sample_t               smp;
	logic                  acc, out_pop;
	logic                  tick, start, stop, photo;
	logic [2:0]            levels, rise;
	logic                  fault;
	logic [DELAY_BITS-1:0] lim, timer_adv;
	logic                  wait_done, fill_done;
	result_t               res;

	assign smp     = sample.data;
	assign acc     = sample.valid && sample.ready;
	assign out_pop = out_valid_q && result.ready;

	// skid entry free means room for one more result
	assign sample.ready = !skid_valid_q;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assign tick   = smp.ms_tick;
	assign start  = !smp.start_button_n;
	assign stop   = !smp.stop_button_n;
	assign photo  = smp.photocell_level;
	assign levels = {smp.lower_limit, smp.upper_limit, smp.photocell_level};
	assign rise   = levels & ~prev_q;

	// the one delay that the current phase is timing
	always_comb begin
		case (phase_q)
			PH_SETTLE:                                  lim = sat_delay(settle_delay_q);
			PH_FILL1, PH_FILL2, PH_DFILL1, PH_DFILL2:   lim = sat_delay(fill_time_q);
			PH_JAWOPEN:                                 lim = sat_delay(jaw_open_q);
			PH_BLADE, PH_DBLADE:                        lim = sat_delay(blade_time_q);
			PH_RELEASE, PH_DRELEASE:                    lim = sat_delay(release_time_q);
			default:                                    lim = '0;
		endcase
	end

	assign wait_done = (timer_q >= lim);
	// timer clears once it reaches the limit, so it never wraps
	assign timer_adv = wait_done ? '0 : (tick ? timer_q + DELAY_BITS'(1) : timer_q);
	assign fill_done = photo_mode_q ? !photo : wait_done;

	always_comb begin
		phase_n   = phase_q;
		timer_n   = timer_q;
		count_n   = count_q;
		arrived_n = arrived_q;
		paused_n  = paused_q;
		act_n     = act_q;
		fault     = 1'b0;

		// edge effects come before the phase action, not while homing
		if (phase_q != PH_HOMING) begin
			if (rise[1:0] != 2'b00) begin
				arrived_n  = 1'b1;
				act_n.slow = 1'b0;
				act_n.med  = 1'b0;
			end
			if (rise[2]) begin
				arrived_n   = 1'b1;
				act_n.slow  = 1'b0;
				act_n.med   = 1'b0;
				act_n.blade = 1'b0;
				act_n.hjaw  = 1'b0;
				fault       = 1'b1;
			end
		end

		case (phase_q)
			PH_HOMING: begin
				if (smp.upper_limit) begin
					arrived_n  = 1'b1;
					act_n.slow = 1'b0;
					act_n.med  = 1'b0;
					phase_n    = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (start) begin
					count_n = sat_count(batch_size_q);
					phase_n = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (count_q == '0) begin
					// batch done or empty batch
					paused_n = 1'b0;
					phase_n  = PH_IDLE;
				end else if (paused_q || stop) begin
					paused_n = 1'b1;
					if (start) begin
						paused_n = 1'b0;
						timer_n  = '0;
						phase_n  = PH_SETTLE;
					end
				end else begin
					timer_n = '0;
					phase_n = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.down = 1'b1;
					act_n.hjaw = 1'b1;
					phase_n    = dry_run_q ? PH_DFILL1 : PH_FILL1;
				end
			end
			PH_FILL1: begin
				if (!photo_mode_q) timer_n = timer_adv;
				if (fill_done) begin
					act_n.med   = 1'b1;
					act_n.slow  = 1'b0;
					act_n.doser = 1'b0;
					phase_n     = PH_FILL2;
				end
			end
			PH_FILL2: begin
				if (!photo_mode_q) timer_n = timer_adv;
				if (fill_done) begin
					act_n.hjaw = 1'b0;
					act_n.vjaw = 1'b1;
					phase_n    = PH_JAWOPEN;
				end
			end
			PH_JAWOPEN: begin
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.down  = 1'b0;
					act_n.blade = 1'b1;
					phase_n     = PH_BLADE;
				end
			end
			PH_BLADE: begin
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.doser = 1'b1;
					act_n.blade = 1'b0;
					phase_n     = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.vjaw = 1'b0;
					if (count_q != '0) count_n = count_q - COUNT_BITS'(1);
					phase_n = PH_WAITUP;
				end
			end
			PH_DFILL1: begin
				// first dry-run fill is always timed
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.med  = 1'b1;
					act_n.slow = 1'b0;
					phase_n    = PH_DFILL2;
				end
			end
			PH_DFILL2: begin
				if (!photo_mode_q) timer_n = timer_adv;
				if (fill_done) begin
					act_n.hjaw  = 1'b0;
					act_n.down  = 1'b0;
					act_n.vjaw  = 1'b1;
					act_n.blade = 1'b1;
					phase_n     = PH_DBLADE;
				end
			end
			PH_DBLADE: begin
				timer_n = timer_adv;
				if (wait_done) begin
					act_n.blade = 1'b0;
					act_n.vjaw  = 1'b0;
					phase_n     = PH_DRELEASE;
				end
			end
			PH_DRELEASE: begin
				timer_n = timer_adv;
				if (wait_done) begin
					if (count_q != '0) count_n = count_q - COUNT_BITS'(1);
					phase_n = PH_WAITUP;
				end
			end
			PH_WAITUP: begin
				// a rising limit or photocell edge during the bag counts here
				if (arrived_n) begin
					arrived_n = 1'b0;
					phase_n   = PH_CHECK;
				end
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	always_comb begin
		res.carriage_down         = act_n.down;
		res.horizontal_jaw_closed = act_n.hjaw;
		res.vertical_jaw_closed   = act_n.vjaw;
		res.blade_on              = act_n.blade;
		res.doser_open            = act_n.doser;
		res.slow_speed_select     = act_n.slow;
		res.medium_speed_select   = act_n.med;
		res.bags_remaining        = 16'(count_n);
		res.running               = (phase_n != PH_HOMING) && (phase_n != PH_IDLE);
		res.homing                = (phase_n == PH_HOMING);
		res.bottom_fault          = fault;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_delay_q <= SETTLE_DELAY_RST;
			fill_time_q    <= FILL_TIME_RST;
			blade_time_q   <= BLADE_TIME_RST;
			release_time_q <= RELEASE_TIME_RST;
			jaw_open_q     <= JAW_OPEN_RST;
			photo_mode_q   <= 1'b0;
			dry_run_q      <= 1'b0;
			batch_size_q   <= BATCH_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_SETTLE_DELAY: settle_delay_q <= cfg_wdata;
				REG_FILL_TIME:    fill_time_q    <= cfg_wdata;
				REG_BLADE_TIME:   blade_time_q   <= cfg_wdata;
				REG_RELEASE_TIME: release_time_q <= cfg_wdata;
				REG_JAW_OPEN:     jaw_open_q     <= cfg_wdata;
				REG_PHOTO_MODE:   photo_mode_q   <= cfg_wdata[0];
				REG_DRY_RUN:      dry_run_q      <= cfg_wdata[0];
				REG_BATCH_SIZE:   batch_size_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer state advances once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HOMING;
			timer_q   <= '0;
			count_q   <= '0;
			arrived_q <= 1'b0;
			paused_q  <= 1'b0;
			prev_q    <= '0;
			act_q     <= ACT_RST;
		end else if (acc) begin
			phase_q   <= phase_n;
			timer_q   <= timer_n;
			count_q   <= count_n;
			arrived_q <= arrived_n;
			paused_q  <= paused_n;
			prev_q    <= levels;
			act_q     <= act_n;
		end
	end

	// result register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_pop) begin
			if (skid_valid_q) out_data_q <= skid_data_q;
			else if (acc)     out_data_q <= res;
		end else if (acc) begin
			skid_data_q <= res;
		end
	end

	// assertions
	`BAGC_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with result register empty")
	`BAGC_ASSERT(a_stall_fills_skid, (acc && out_valid_q && !out_pop) |=> skid_valid_q, "stalled result lost")
	`BAGC_ASSERT(a_drain_empties, (out_pop && !skid_valid_q && !acc) |=> !out_valid_q, "result repeated after drain")

endmodule
